[design/cnbs_pkg.sv]
package cnbs_pkg;

    localparam int OUT_WIDTH   = 16;
    localparam int OUT_TDATA_W = ((OUT_WIDTH + 7) / 8) * 8;
    localparam int RND_SHIFT   = 32 - OUT_WIDTH;
    localparam int SMP_W       = 35 - RND_SHIFT;

    localparam logic [31:0] NOISE_SEED = 32'h6d2b79f5;
    localparam logic [31:0] SIGN_FLIP  = 32'h80000000;
    localparam logic [15:0] HP_COEF    = 16'd57672;
    localparam logic [13:0] GAIN_COEF  = 14'd9175;
    localparam logic [24:0] ENV_ONE    = 25'h1000000;
    localparam logic [48:0] ENV_HALF   = 49'd8388608;

    localparam logic [15:0] CLIP_LENGTH_RST  = 16'd6720;
    localparam logic [15:0] SECOND_BURST_RST = 16'd864;
    localparam logic [15:0] THIRD_BURST_RST  = 16'd1728;
    localparam logic [23:0] DECAY_RST        = 24'd16755559;

    typedef enum logic [1:0] {
        REG_CLIP_LENGTH  = 2'd0,
        REG_SECOND_BURST = 2'd1,
        REG_THIRD_BURST  = 2'd2,
        REG_DECAY        = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_HP,
        ST_MUL,
        ST_SUM,
        ST_GAIN,
        ST_RND,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic restart;
        logic step;
        logic zero;
        logic hp;
        logic mul;
        logic sum;
        logic gain;
        logic rnd;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic frame_ge_len;
        logic frame_last;
        logic out_busy;
    } status_t;

endpackage

[design/cnbs_ctrl.sv]
module cnbs_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              start_req,
    input  cnbs_pkg::status_t status,
    output logic              s_tready,
    output cnbs_pkg::cmd_t    cmd
);

    cnbs_pkg::state_t state_reg;
    cnbs_pkg::state_t state_next;
    logic             playing_reg;
    logic             playing_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= cnbs_pkg::ST_IDLE;
            playing_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            playing_reg <= playing_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        playing_next = playing_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        unique case (state_reg)
            cnbs_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = cnbs_pkg::ST_CHECK;
                    if (start_req)
                    begin
                        cmd.restart  = 1'b1;
                        playing_next = 1'b1;
                    end
                end
            end
            cnbs_pkg::ST_CHECK:
            begin
                // idle or counter already past the clip: zero result
                if (!playing_reg || status.frame_ge_len)
                begin
                    cmd.zero     = 1'b1;
                    playing_next = 1'b0;
                    state_next   = cnbs_pkg::ST_EMIT;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = cnbs_pkg::ST_HP;
                    if (status.frame_last)
                    begin
                        playing_next = 1'b0;
                    end
                end
            end
            cnbs_pkg::ST_HP:
            begin
                cmd.hp     = 1'b1;
                state_next = cnbs_pkg::ST_MUL;
            end
            cnbs_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = cnbs_pkg::ST_SUM;
            end
            cnbs_pkg::ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = cnbs_pkg::ST_GAIN;
            end
            cnbs_pkg::ST_GAIN:
            begin
                cmd.gain   = 1'b1;
                state_next = cnbs_pkg::ST_RND;
            end
            cnbs_pkg::ST_RND:
            begin
                cmd.rnd    = 1'b1;
                state_next = cnbs_pkg::ST_EMIT;
            end
            cnbs_pkg::ST_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = cnbs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cnbs_pkg::ST_IDLE;
            end
        endcase
    end

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !status.out_busy)
        else $error("result loaded while previous result still waiting");

    a_restart_plays: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && start_req) |=> playing_reg)
        else $error("start request did not begin a clap");

    a_step_only_playing: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (playing_reg && !status.frame_ge_len))
        else $error("frame stepped outside a clap");

    a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && status.frame_last) |=> !playing_reg)
        else $error("clap kept playing past its last frame");

endmodule

[design/cnbs_datapath.sv]
module cnbs_datapath
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [1:0]                       cfg_addr,
    input  logic [23:0]                      cfg_wdata,
    input  cnbs_pkg::cmd_t                   cmd,
    input  logic                             m_tready,
    output cnbs_pkg::status_t                status,
    output logic                             m_tvalid,
    output logic [cnbs_pkg::OUT_WIDTH-1:0]   sample_value,
    output logic                             active,
    output logic                             final_frame
);

    logic [15:0] clip_len_reg;
    logic [15:0] burst2_reg;
    logic [15:0] burst3_reg;
    logic [23:0] decay_reg;

    logic [31:0]        noise_reg;
    logic signed [31:0] prev_reg;
    logic [24:0]        env1_reg;
    logic [24:0]        env2_reg;
    logic [24:0]        env3_reg;
    logic [15:0]        frame_reg;
    logic               last_reg;
    logic               zero_reg;

    logic signed [31:0] n_reg;
    logic signed [48:0] hprod_reg;
    logic signed [32:0] hp_reg;
    logic [25:0]        esum_reg;
    logic [42:0]        plo_reg;
    logic signed [42:0] phi_reg;
    logic signed [35:0] p_reg;
    logic signed [50:0] gprod_reg;
    logic signed [34:0] q_reg;

    logic                           out_valid_reg;
    logic [cnbs_pkg::OUT_WIDTH-1:0] out_sample_reg;
    logic                           out_active_reg;
    logic                           out_last_reg;

    logic [31:0]                    xs1;
    logic [31:0]                    xs2;
    logic [31:0]                    xs3;
    logic signed [16:0]             hp_coef_s;
    logic signed [14:0]             gain_s;
    logic signed [26:0]             esum_s;
    logic signed [48:0]             hprod_next;
    logic signed [48:0]             hsum;
    logic signed [32:0]             hp_next;
    logic signed [59:0]             psum;
    logic signed [50:0]             gprod_next;
    logic signed [50:0]             qsum;
    logic signed [34:0]             ssum;
    logic signed [cnbs_pkg::SMP_W-1:0] smp;
    logic [cnbs_pkg::OUT_WIDTH-1:0] sat;
    logic                           ovf;

    function automatic logic [24:0] next_env(
        input logic [24:0] env,
        input logic [15:0] start,
        input logic [15:0] f,
        input logic [23:0] decay
    );
        logic [48:0] prod;
        prod = 49'(env) * 49'(decay) + cnbs_pkg::ENV_HALF;
        if (f == start)
        begin
            return cnbs_pkg::ENV_ONE;
        end
        else if (f > start)
        begin
            return prod[48:24];
        end
        return 25'd0;
    endfunction

    // xorshift32 with shifts 13, 17, 5
    assign xs1 = noise_reg ^ (noise_reg << 13);
    assign xs2 = xs1 ^ (xs1 >> 17);
    assign xs3 = xs2 ^ (xs2 << 5);

    assign hp_coef_s  = {1'b0, cnbs_pkg::HP_COEF};
    assign gain_s     = {1'b0, cnbs_pkg::GAIN_COEF};
    assign esum_s     = {1'b0, esum_reg};
    assign hprod_next = prev_reg * hp_coef_s;
    assign hsum       = hprod_reg + 49'sd32768;
    assign hp_next    = {n_reg[31], n_reg} - $signed(hsum[48:16]);
    assign psum       = ({{17{phi_reg[42]}}, phi_reg} <<< 17)
                        + $signed({17'b0, plo_reg}) + 60'sd8388608;
    assign gprod_next = p_reg * gain_s;
    assign qsum       = gprod_reg + 51'sd32768;
    assign ssum       = q_reg + (35'sd1 <<< (cnbs_pkg::RND_SHIFT - 1));
    assign smp        = ssum[34:cnbs_pkg::RND_SHIFT];

    // saturate to the signed output range
    assign ovf = (smp[cnbs_pkg::SMP_W-1:cnbs_pkg::OUT_WIDTH-1] != '0)
              && (smp[cnbs_pkg::SMP_W-1:cnbs_pkg::OUT_WIDTH-1] != '1);
    assign sat = ovf ? {smp[cnbs_pkg::SMP_W-1], {(cnbs_pkg::OUT_WIDTH-1){~smp[cnbs_pkg::SMP_W-1]}}}
                     : smp[cnbs_pkg::OUT_WIDTH-1:0];

    assign status.frame_ge_len = (frame_reg >= clip_len_reg);
    assign status.frame_last   = (frame_reg == clip_len_reg - 16'd1);
    assign status.out_busy     = out_valid_reg && !m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_len_reg <= cnbs_pkg::CLIP_LENGTH_RST;
            burst2_reg   <= cnbs_pkg::SECOND_BURST_RST;
            burst3_reg   <= cnbs_pkg::THIRD_BURST_RST;
            decay_reg    <= cnbs_pkg::DECAY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cnbs_pkg::cfg_index_t'(cfg_addr))
                cnbs_pkg::REG_CLIP_LENGTH:  clip_len_reg <= cfg_wdata[15:0];
                cnbs_pkg::REG_SECOND_BURST: burst2_reg   <= cfg_wdata[15:0];
                cnbs_pkg::REG_THIRD_BURST:  burst3_reg   <= cfg_wdata[15:0];
                cnbs_pkg::REG_DECAY:        decay_reg    <= cfg_wdata;
                default:                    decay_reg    <= decay_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_reg <= cnbs_pkg::NOISE_SEED;
            prev_reg  <= '0;
            env1_reg  <= '0;
            env2_reg  <= '0;
            env3_reg  <= '0;
            frame_reg <= '0;
            last_reg  <= 1'b0;
            zero_reg  <= 1'b1;
        end
        else
        begin
            if (cmd.restart)
            begin
                noise_reg <= cnbs_pkg::NOISE_SEED;
                prev_reg  <= '0;
                env1_reg  <= '0;
                env2_reg  <= '0;
                env3_reg  <= '0;
                frame_reg <= '0;
            end
            if (cmd.zero)
            begin
                zero_reg <= 1'b1;
            end
            if (cmd.step)
            begin
                noise_reg <= xs3;
                prev_reg  <= $signed(xs3 ^ cnbs_pkg::SIGN_FLIP);
                env1_reg  <= next_env(env1_reg, 16'd0, frame_reg, decay_reg);
                env2_reg  <= next_env(env2_reg, burst2_reg, frame_reg, decay_reg);
                env3_reg  <= next_env(env3_reg, burst3_reg, frame_reg, decay_reg);
                last_reg  <= status.frame_last;
                zero_reg  <= 1'b0;
                if (!status.frame_last)
                begin
                    frame_reg <= frame_reg + 16'd1;
                end
            end
        end
    end

    // arithmetic pipeline, one step per controller state
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            n_reg     <= $signed(xs3 ^ cnbs_pkg::SIGN_FLIP);
            hprod_reg <= hprod_next;
        end
        if (cmd.hp)
        begin
            hp_reg   <= hp_next;
            esum_reg <= 26'(env1_reg) + 26'(env2_reg) + 26'(env3_reg);
        end
        if (cmd.mul)
        begin
            // split product: low 17 bits unsigned, high 16 bits signed
            plo_reg <= 43'(hp_reg[16:0]) * 43'(esum_reg);
            phi_reg <= $signed(hp_reg[32:17]) * esum_s;
        end
        if (cmd.sum)
        begin
            p_reg <= psum[59:24];
        end
        if (cmd.gain)
        begin
            gprod_reg <= gprod_next;
        end
        if (cmd.rnd)
        begin
            q_reg <= qsum[50:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_sample_reg <= zero_reg ? '0 : sat;
            out_active_reg <= !zero_reg;
            out_last_reg   <= !zero_reg && last_reg;
        end
    end

    assign m_tvalid     = out_valid_reg;
    assign sample_value = out_sample_reg;
    assign active       = out_active_reg;
    assign final_frame  = out_last_reg;

endmodule

[design/clap_noise_burst_synthesizer_unit.sv]
// a playing request steps the shared arithmetic pipeline through its six
// stages (check, high-pass, multiply, sum, gain, rounding) before emit;
// a request finding the voice idle or past the clip goes from check to
// emit; emit waits on back-pressure; new requests are taken only in idle
// reset: asynchronous, active low; configuration registers return to their
// default values, the voice is idle and the noise seed is loaded
module clap_noise_burst_synthesizer_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [0] start_req
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [cnbs_pkg::OUT_TDATA_W-1:0]   m_tdata,   // sample_value
    output logic                               m_tuser,   // active
    output logic                               m_tlast,   // final_frame
    input  logic                               cfg_we,
    input  logic [1:0]                         cfg_addr,
    input  logic [23:0]                        cfg_wdata
);

    cnbs_pkg::cmd_t                 cmd;
    cnbs_pkg::status_t              status;
    logic [cnbs_pkg::OUT_WIDTH-1:0] sample_value;

    cnbs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .start_req (s_tdata[0]),
        .status    (status),
        .s_tready  (s_tready),
        .cmd       (cmd)
    );

    cnbs_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .m_tready     (m_tready),
        .status       (status),
        .m_tvalid     (m_tvalid),
        .sample_value (sample_value),
        .active       (m_tuser),
        .final_frame  (m_tlast)
    );

    assign m_tdata = cnbs_pkg::OUT_TDATA_W'(sample_value);

endmodule
